### design/otb_pkg.sv
// ----------------------------------------------------------------------------
// One-shot timer bank package
// Shared widths, codes and the command and status types that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package otb_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int TIME_W_DEF   = 32;
    localparam int OP_W         = 2;
    localparam int SLOT_FIELD_W = 4;
    localparam int DUR_W        = 32;
    localparam int NOW_W        = 32;
    localparam int KIND_W       = 2;
    localparam int MS_W         = 10;
    localparam int MUL_W        = DUR_W + MS_W;

    localparam logic [MS_W-1:0] MS_TO_US = MS_W'(1000);

    localparam logic [OP_W-1:0] OP_PAUSE_US = 2'd0;
    localparam logic [OP_W-1:0] OP_PAUSE_MS = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_PAUSE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESUMED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

    typedef struct packed {
        logic load_req;
        logic do_pause;
        logic rd_en;
        logic cmp_en;
        logic finish;
    } otb_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hit;
        logic pend_valid;
    } otb_status_t;

endpackage

### design/otb_if.sv
// ----------------------------------------------------------------------------
// One-shot timer bank channels
// Valid and ready channels for requests into the bank and results out of it.
// ----------------------------------------------------------------------------
interface otb_req_if;
    import otb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [DUR_W-1:0]        duration;
    logic [NOW_W-1:0]        now_time;
    logic                    notify;

    modport source (
        output valid, op, slot, duration, now_time, notify,
        input  ready
    );

    modport sink (
        input  valid, op, slot, duration, now_time, notify,
        output ready
    );
endinterface

interface otb_rsp_if;
    import otb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic                    accepted;
    logic                    had_callback;
    logic                    last_item;

    modport source (
        output valid, kind, slot_out, accepted, had_callback, last_item,
        input  ready
    );

    modport sink (
        input  valid, kind, slot_out, accepted, had_callback, last_item,
        output ready
    );
endinterface

### design/otb_datapath.sv
// ----------------------------------------------------------------------------
// One-shot timer bank datapath
// Request register, timer store, slot flags, expiry compare, pending resume
// result and the output register.
// ----------------------------------------------------------------------------
module otb_datapath #(
    parameter int SLOTS  = 16,
    parameter int TIME_W = 32,
    parameter int SLOT_W = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  otb_pkg::otb_cmd_t                cmd,
    input  logic [SLOT_W-1:0]                rd_addr,
    input  logic [SLOT_W-1:0]                cmp_addr,
    input  logic [otb_pkg::OP_W-1:0]         req_op,
    input  logic [otb_pkg::SLOT_FIELD_W-1:0] req_slot,
    input  logic [otb_pkg::DUR_W-1:0]        req_duration,
    input  logic [otb_pkg::NOW_W-1:0]        req_now_time,
    input  logic                             req_notify,
    input  logic                             rsp_ready,
    output otb_pkg::otb_status_t             status,
    output logic                             rsp_valid,
    output logic [otb_pkg::KIND_W-1:0]       rsp_kind,
    output logic [otb_pkg::SLOT_FIELD_W-1:0] rsp_slot_out,
    output logic                             rsp_accepted,
    output logic                             rsp_had_callback,
    output logic                             rsp_last_item
);
    import otb_pkg::*;

    localparam int CMP_W = SLOT_W + SLOT_FIELD_W + 1;

    logic [SLOT_FIELD_W-1:0] slot_reg;
    logic [DUR_W-1:0]        dur_reg;
    logic [TIME_W-1:0]       now_reg;
    logic                    ms_reg;
    logic                    notify_reg;

    logic [TIME_W-1:0] len_mem   [SLOTS];
    logic [TIME_W-1:0] start_mem [SLOTS];
    logic [TIME_W-1:0] len_q_reg;
    logic [TIME_W-1:0] start_q_reg;

    logic [SLOTS-1:0] paused_reg;
    logic [SLOTS-1:0] paused_next;
    logic [SLOTS-1:0] cb_reg;
    logic [SLOTS-1:0] cb_next;

    logic                    pend_valid_reg;
    logic                    pend_valid_next;
    logic [SLOT_FIELD_W-1:0] pend_slot_reg;
    logic [SLOT_FIELD_W-1:0] pend_slot_next;
    logic                    pend_cb_reg;
    logic                    pend_cb_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [KIND_W-1:0]       out_kind_reg;
    logic [KIND_W-1:0]       out_kind_next;
    logic [SLOT_FIELD_W-1:0] out_slot_reg;
    logic [SLOT_FIELD_W-1:0] out_slot_next;
    logic                    out_acc_reg;
    logic                    out_acc_next;
    logic                    out_cb_reg;
    logic                    out_cb_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    logic [SLOT_W-1:0] pause_idx;
    logic              in_range;
    logic              pause_ok;
    logic [MUL_W-1:0]  product;
    logic [TIME_W-1:0] pause_len;
    logic [TIME_W-1:0] elapsed;
    logic              hit;
    logic              out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            slot_reg   <= req_slot;
            dur_reg    <= req_duration;
            now_reg    <= TIME_W'(req_now_time);
            ms_reg     <= (req_op == OP_PAUSE_MS);
            notify_reg <= req_notify;
        end
    end

    assign pause_idx = SLOT_W'(slot_reg);
    assign in_range  = CMP_W'(slot_reg) < CMP_W'(SLOTS);
    assign pause_ok  = in_range && !paused_reg[pause_idx];
    assign product   = MUL_W'(dur_reg) * MUL_W'(MS_TO_US);
    assign pause_len = ms_reg ? TIME_W'(product) : TIME_W'(dur_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.do_pause && pause_ok)
        begin
            len_mem[pause_idx]   <= pause_len;
            start_mem[pause_idx] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            len_q_reg   <= len_mem[rd_addr];
            start_q_reg <= start_mem[rd_addr];
        end
    end

    assign elapsed  = now_reg - start_q_reg;
    assign hit      = paused_reg[cmp_addr] && (elapsed >= len_q_reg);
    assign out_free = !out_valid_reg || rsp_ready;

    assign status.out_free   = out_free;
    assign status.hit        = hit;
    assign status.pend_valid = pend_valid_reg;

    always_comb
    begin
        paused_next     = paused_reg;
        cb_next         = cb_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_cb_next    = pend_cb_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_acc_next    = out_acc_reg;
        out_cb_next     = out_cb_reg;
        out_last_next   = out_last_reg;

        if (cmd.do_pause)
        begin
            if (pause_ok)
            begin
                paused_next[pause_idx] = 1'b1;
                cb_next[pause_idx]     = notify_reg;
            end
            out_valid_next = 1'b1;
            out_kind_next  = KIND_PAUSE;
            out_slot_next  = slot_reg;
            out_acc_next   = pause_ok;
            out_cb_next    = 1'b0;
            out_last_next  = 1'b1;
        end

        if (cmd.cmp_en && hit)
        begin
            paused_next[cmp_addr] = 1'b0;
            cb_next[cmp_addr]     = 1'b0;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_RESUMED;
                out_slot_next  = pend_slot_reg;
                out_acc_next   = 1'b0;
                out_cb_next    = pend_cb_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_slot_next  = SLOT_FIELD_W'(cmp_addr);
            pend_cb_next    = cb_reg[cmp_addr];
        end

        if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_acc_next    = 1'b0;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_kind_next = KIND_RESUMED;
                out_slot_next = pend_slot_reg;
                out_cb_next   = pend_cb_reg;
            end
            else
            begin
                out_kind_next = KIND_NONE;
                out_slot_next = '0;
                out_cb_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg     <= '0;
            cb_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            paused_reg     <= paused_next;
            cb_reg         <= cb_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_cb_reg   <= pend_cb_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_acc_reg   <= out_acc_next;
        out_cb_reg    <= out_cb_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_kind         = out_kind_reg;
    assign rsp_slot_out     = out_slot_reg;
    assign rsp_accepted     = out_acc_reg;
    assign rsp_had_callback = out_cb_reg;
    assign rsp_last_item    = out_last_reg;

endmodule

### design/otb_ctrl.sv
// ----------------------------------------------------------------------------
// One-shot timer bank controller
// Sequences pause requests and the slot scan of a check request, and holds
// the scan when a resume result cannot be handed on.
// ----------------------------------------------------------------------------
module otb_ctrl #(
    parameter int SLOTS  = 16,
    parameter int SLOT_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic [otb_pkg::OP_W-1:0] req_op,
    output logic                     req_ready,
    input  otb_pkg::otb_status_t     status,
    output otb_pkg::otb_cmd_t        cmd,
    output logic [SLOT_W-1:0]        rd_addr,
    output logic [SLOT_W-1:0]        cmp_addr
);
    import otb_pkg::*;

    localparam int CNT_W = SLOT_W + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PAUSE  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic [CNT_W-1:0]  rd_cnt_next;
    logic              cmp_vld_reg;
    logic              cmp_vld_next;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic [SLOT_W-1:0] cmp_idx_next;
    logic              stall;

    assign req_ready = (state_reg == ST_IDLE);
    assign rd_addr   = rd_cnt_reg[SLOT_W-1:0];
    assign cmp_addr  = cmp_idx_reg;
    assign stall     = cmp_vld_reg && status.hit && status.pend_valid && !status.out_free;

    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        cmd          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    case (req_op)
                        OP_PAUSE_US, OP_PAUSE_MS:
                        begin
                            state_next = ST_PAUSE;
                        end
                        OP_CHECK:
                        begin
                            state_next   = ST_SCAN;
                            rd_cnt_next  = '0;
                            cmp_vld_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PAUSE:
            begin
                if (status.out_free)
                begin
                    cmd.do_pause = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    cmd.cmp_en = cmp_vld_reg;
                    if (rd_cnt_reg < CNT_W'(SLOTS))
                    begin
                        cmd.rd_en    = 1'b1;
                        cmp_vld_next = 1'b1;
                        cmp_idx_next = rd_cnt_reg[SLOT_W-1:0];
                        rd_cnt_next  = rd_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cmp_vld_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            cmp_idx_reg <= cmp_idx_next;
        end
    end

endmodule

### design/one_shot_pause_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// One-shot pause timer bank
// A bank of one-shot pause timers, one per slot, with pause and check
// requests and one result per pause, per released slot, or per check that releases none.
// ----------------------------------------------------------------------------
// The bank takes one request at a time. A pause request is answered once the
// output register is free, and the next request can be taken from the edge
// at which that answer is registered. A check request reads the slots one
// per cycle, while the scan is not held, through the single read port of the
// timer store; a resume result that waits on the sink holds the scan.
// Each released slot gives one result, and a check that releases none gives
// one none-expired result; the final result of a request has last_item set.
module one_shot_pause_timer_bank_unit #(
    parameter int SLOTS  = otb_pkg::SLOTS_DEF,
    parameter int TIME_W = otb_pkg::TIME_W_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    otb_req_if.sink   request,
    otb_rsp_if.source result
);
    import otb_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    otb_cmd_t          cmd;
    otb_status_t       status;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] cmp_addr;

    otb_ctrl #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_op    (request.op),
        .req_ready (request.ready),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .cmp_addr  (cmp_addr)
    );

    otb_datapath #(
        .SLOTS  (SLOTS),
        .TIME_W (TIME_W),
        .SLOT_W (SLOT_W)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .rd_addr          (rd_addr),
        .cmp_addr         (cmp_addr),
        .req_op           (request.op),
        .req_slot         (request.slot),
        .req_duration     (request.duration),
        .req_now_time     (request.now_time),
        .req_notify       (request.notify),
        .rsp_ready        (result.ready),
        .status           (status),
        .rsp_valid        (result.valid),
        .rsp_kind         (result.kind),
        .rsp_slot_out     (result.slot_out),
        .rsp_accepted     (result.accepted),
        .rsp_had_callback (result.had_callback),
        .rsp_last_item    (result.last_item)
    );

endmodule
